// File: hdl/scl_pkg.sv
// shell command lexer: shared types, token kind codes and byte constants
// no dependencies; used by scl_if, scl_step, scl_queue and the top level
`default_nettype none
package scl_pkg;

	localparam int unsigned TOKEN_W = 6;

	// token kinds
	localparam logic [2:0] KIND_CHAR   = 3'd0;
	localparam logic [2:0] KIND_END    = 3'd1;
	localparam logic [2:0] KIND_AND_IF = 3'd2;
	localparam logic [2:0] KIND_APPEND = 3'd3;
	localparam logic [2:0] KIND_OUT    = 3'd4;
	localparam logic [2:0] KIND_IN     = 3'd5;
	localparam logic [2:0] KIND_PIPE   = 3'd6;
	localparam logic [2:0] KIND_DONE   = 3'd7;

	// quote state
	localparam logic [1:0] QUOTE_NONE   = 2'd0;
	localparam logic [1:0] QUOTE_SINGLE = 2'd1;
	localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

	// lookahead state
	localparam logic [1:0] HELD_NONE = 2'd0;
	localparam logic [1:0] HELD_AMP  = 2'd1;
	localparam logic [1:0] HELD_GT   = 2'd2;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_PIPE  = 8'h7C;
	localparam logic [7:0] CH_SQUOT = 8'h27;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       line_end;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [7:0]         char_value;
		logic [TOKEN_W-1:0] token_index;
		logic [TOKEN_W-1:0] token_total;
		logic               last;
	} tok_t;

	typedef struct packed {
		logic               in_word;
		logic [1:0]         quote_mode;
		logic [1:0]         held_char;
		logic [TOKEN_W-1:0] token_count;
	} lex_state_t;

	// up to three words written to the result queue at once
	typedef struct packed {
		logic [1:0]       n;
		tok_t [2:0]       item;
	} push_t;

endpackage
`default_nettype wire

// File: hdl/scl_if.sv
// valid/ready channels of the shell command lexer
// depends on scl_pkg for the payload types
`default_nettype none
interface scl_cmd_if;
	logic          valid;
	logic          ready;
	scl_pkg::cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface scl_tok_if;
	logic          valid;
	logic          ready;
	scl_pkg::tok_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/scl_step.sv
// per-byte lexer step: next state and up to three result words
// combinational; depends on scl_pkg
`default_nettype none
module scl_step #(
	parameter int unsigned TOKEN_CAPACITY = 64
) (
	input  wire scl_pkg::cmd_t      cmd,
	input  wire scl_pkg::lex_state_t cur,
	output scl_pkg::lex_state_t     nxt,
	output scl_pkg::push_t          push
);

	localparam logic [scl_pkg::TOKEN_W:0] CAP = (scl_pkg::TOKEN_W+1)'(TOKEN_CAPACITY);

	function automatic scl_pkg::tok_t mk(input logic [2:0] kind, input logic [7:0] ch,
			input logic [scl_pkg::TOKEN_W-1:0] idx, input logic [scl_pkg::TOKEN_W-1:0] total);
		scl_pkg::tok_t r;
		r.kind        = kind;
		r.char_value  = ch;
		r.token_index = idx;
		r.token_total = total;
		r.last        = 1'b0;
		return r;
	endfunction

	function automatic logic room(input logic [scl_pkg::TOKEN_W-1:0] t);
		return ({1'b0, t} + 1'b1) < CAP;
	endfunction

	logic [7:0] b;
	logic       b_space;
	logic       run_in;
	logic       run_out;
	logic       run_start;
	scl_pkg::lex_state_t st;
	logic [1:0] n;
	scl_pkg::tok_t [2:0] res;

	assign b       = cmd.byte_value;
	assign b_space = (b == scl_pkg::CH_SPACE) || (b >= scl_pkg::CH_TAB && b <= scl_pkg::CH_CR);

	always_comb begin
		st        = cur;
		n         = 2'd0;
		res       = '0;
		run_in    = 1'b0;
		run_out   = 1'b0;
		run_start = 1'b0;
		if (cmd.line_end) begin
			if (cur.held_char == scl_pkg::HELD_AMP) begin
				res[n] = mk(scl_pkg::KIND_CHAR, scl_pkg::CH_AMP, st.token_count, '0);
				n = n + 2'd1;
				st.in_word = 1'b1;
			end else if (cur.held_char == scl_pkg::HELD_GT) begin
				res[n] = mk(scl_pkg::KIND_OUT, 8'd0, st.token_count, '0);
				n = n + 2'd1;
				st.token_count = st.token_count + 1'b1;
			end
			if (st.in_word) begin
				res[n] = mk(scl_pkg::KIND_END, 8'd0, st.token_count, '0);
				n = n + 2'd1;
				st.token_count = st.token_count + 1'b1;
			end
			res[n] = mk(scl_pkg::KIND_DONE, 8'd0, '0, st.token_count);
			n = n + 2'd1;
			st = '0;
		end else if (cur.held_char == scl_pkg::HELD_AMP) begin
			st.held_char = scl_pkg::HELD_NONE;
			if (b == scl_pkg::CH_AMP) begin
				if (st.in_word) begin
					res[n] = mk(scl_pkg::KIND_END, 8'd0, st.token_count, '0);
					n = n + 2'd1;
					st.token_count = st.token_count + 1'b1;
					st.in_word     = 1'b0;
					st.quote_mode  = scl_pkg::QUOTE_NONE;
				end
				if (room(st.token_count)) begin
					res[n] = mk(scl_pkg::KIND_AND_IF, 8'd0, st.token_count, '0);
					n = n + 2'd1;
					st.token_count = st.token_count + 1'b1;
				end
			end else begin
				// a lone '&' becomes a word byte
				res[n] = mk(scl_pkg::KIND_CHAR, scl_pkg::CH_AMP, st.token_count, '0);
				n = n + 2'd1;
				st.in_word = 1'b1;
				run_in = 1'b1;
			end
		end else if (cur.held_char == scl_pkg::HELD_GT) begin
			st.held_char = scl_pkg::HELD_NONE;
			if (b == scl_pkg::CH_GT) begin
				res[n] = mk(scl_pkg::KIND_APPEND, 8'd0, st.token_count, '0);
				n = n + 2'd1;
				st.token_count = st.token_count + 1'b1;
			end else begin
				res[n] = mk(scl_pkg::KIND_OUT, 8'd0, st.token_count, '0);
				n = n + 2'd1;
				st.token_count = st.token_count + 1'b1;
				run_out = 1'b1;
			end
		end else if (cur.in_word) begin
			run_in = 1'b1;
		end else begin
			run_out = 1'b1;
		end

		// inside a word
		if (run_in) begin
			if (st.quote_mode != scl_pkg::QUOTE_NONE) begin
				if ((st.quote_mode == scl_pkg::QUOTE_SINGLE && b == scl_pkg::CH_SQUOT) ||
						(st.quote_mode == scl_pkg::QUOTE_DOUBLE && b == scl_pkg::CH_DQUOT)) begin
					st.quote_mode = scl_pkg::QUOTE_NONE;
				end else begin
					res[n] = mk(scl_pkg::KIND_CHAR, b, st.token_count, '0);
					n = n + 2'd1;
				end
			end else if (b == scl_pkg::CH_SQUOT) begin
				st.quote_mode = scl_pkg::QUOTE_SINGLE;
			end else if (b == scl_pkg::CH_DQUOT) begin
				st.quote_mode = scl_pkg::QUOTE_DOUBLE;
			end else if (b_space || b == scl_pkg::CH_PIPE || b == scl_pkg::CH_GT) begin
				res[n] = mk(scl_pkg::KIND_END, 8'd0, st.token_count, '0);
				n = n + 2'd1;
				st.token_count = st.token_count + 1'b1;
				st.in_word     = 1'b0;
				st.quote_mode  = scl_pkg::QUOTE_NONE;
				run_out = 1'b1;
			end else if (b == scl_pkg::CH_AMP) begin
				st.held_char = scl_pkg::HELD_AMP;
			end else begin
				res[n] = mk(scl_pkg::KIND_CHAR, b, st.token_count, '0);
				n = n + 2'd1;
			end
		end

		// between words
		if (run_out && room(st.token_count) && !b_space) begin
			if (b == scl_pkg::CH_AMP) begin
				st.held_char = scl_pkg::HELD_AMP;
			end else if (b == scl_pkg::CH_GT) begin
				st.held_char = scl_pkg::HELD_GT;
			end else if (b == scl_pkg::CH_LT) begin
				res[n] = mk(scl_pkg::KIND_IN, 8'd0, st.token_count, '0);
				n = n + 2'd1;
				st.token_count = st.token_count + 1'b1;
			end else if (b == scl_pkg::CH_PIPE) begin
				res[n] = mk(scl_pkg::KIND_PIPE, 8'd0, st.token_count, '0);
				n = n + 2'd1;
				st.token_count = st.token_count + 1'b1;
			end else begin
				st.in_word = 1'b1;
				run_start  = 1'b1;
			end
		end

		// first byte of a new word, no quote open yet
		if (run_start) begin
			if (b == scl_pkg::CH_SQUOT) begin
				st.quote_mode = scl_pkg::QUOTE_SINGLE;
			end else if (b == scl_pkg::CH_DQUOT) begin
				st.quote_mode = scl_pkg::QUOTE_DOUBLE;
			end else begin
				res[n] = mk(scl_pkg::KIND_CHAR, b, st.token_count, '0);
				n = n + 2'd1;
			end
		end

		if (n != 2'd0) begin
			res[n - 2'd1].last = 1'b1;
		end
	end

	assign nxt       = st;
	assign push.n    = n;
	assign push.item = res;

endmodule
`default_nettype wire

// File: hdl/scl_queue.sv
// four-entry result queue: takes up to three words a cycle, gives one when the receiver is ready
// depends on scl_pkg and scl_tok_if
`default_nettype none
module scl_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire scl_pkg::push_t push,
	output logic             space_ok,
	scl_tok_if.source        tok
);

	localparam int unsigned DEPTH = 4;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	scl_pkg::tok_t mem [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          pop;

	assign pop       = tok.valid && tok.ready;
	assign tok.valid = cnt_q != '0;
	assign tok.data  = mem[rd_q];
	// room for a full three-word push
	assign space_ok  = cnt_q <= CW'(DEPTH - 3);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < push.n) begin
				mem[wr_q + AW'(i)] <= push.item[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(push.n);
			rd_q  <= rd_q + AW'(pop);
			cnt_q <= cnt_q + CW'(push.n) - CW'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(DEPTH))
		else $error("result queue overfilled");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> space_ok)
		else $error("push without room");
	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.n == 2'd0) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count lost a pop");

endmodule
`default_nettype wire

// File: hdl/shell_command_lexer_core.sv
// shell command lexer: byte stream in, word/operator tokens out
// each accepted byte is registered, lexed combinationally and queued for output
// throughput: one byte per cycle while the result queue holds at most one word; after
// a byte that gives two or three words the next byte waits in the input register
// while the four-entry result queue drains to one word
// reset: asynchronous, clears lexer state, input register valid and queue pointers
`default_nettype none
module shell_command_lexer_core #(
	parameter int unsigned TOKEN_CAPACITY = 64
) (
	input  wire       clk,
	input  wire       arst_n,
	scl_cmd_if.sink   cmd,
	scl_tok_if.source tok
);

	scl_pkg::cmd_t       cmd_s1;
	logic                valid_s1;
	scl_pkg::lex_state_t state_q;
	scl_pkg::lex_state_t state_nxt;
	scl_pkg::push_t      step_push;
	scl_pkg::push_t      push;
	logic                space_ok;
	logic                fire;

	assign fire      = valid_s1 && space_ok;
	assign cmd.ready = !valid_s1 || fire;

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '0;
		end else begin
			valid_s1 <= (cmd.valid && cmd.ready) || (valid_s1 && !fire);
			if (fire) begin
				state_q <= state_nxt;
			end
		end
	end

	scl_step #(.TOKEN_CAPACITY(TOKEN_CAPACITY)) u_step (
		.cmd  (cmd_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.push (step_push)
	);

	always_comb begin
		push = step_push;
		if (!fire) begin
			push.n = 2'd0;
		end
	end

	scl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.tok      (tok)
	);

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, state_q.token_count} < (scl_pkg::TOKEN_W+1)'(TOKEN_CAPACITY))
		else $error("token count past capacity");
	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cmd_s1.line_end) |=> state_q == '0)
		else $error("state not cleared at line end");
	a_held_unquoted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.held_char != scl_pkg::HELD_NONE) |-> state_q.quote_mode == scl_pkg::QUOTE_NONE)
		else $error("lookahead held inside quotes");

endmodule
`default_nettype wire

// File: tb/tb_shell_command_lexer_core.sv
// self-checking bench for shell_command_lexer_core: byte words in, token words out
// depends on scl_pkg and the scl_cmd_if / scl_tok_if channels; a local lexer model
// predicts every token word, which is checked in order against the output channel
module tb_shell_command_lexer_core;

	localparam int unsigned TOKEN_CAPACITY = 64;
	localparam int unsigned DIRECTED_PLUS_RANDOM = 525;
	localparam int unsigned HOLD_CYCLES = 80;

	logic clk;
	logic arst_n;

	scl_cmd_if cmd_ch ();
	scl_tok_if tok_ch ();

	shell_command_lexer_core #(
		.TOKEN_CAPACITY(TOKEN_CAPACITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.tok(tok_ch)
	);

	// stimulus and expectations
	scl_pkg::cmd_t pending_cmds[$];
	scl_pkg::tok_t expected_toks[$];
	scl_pkg::tok_t step_toks[$];

	// lexer model state
	logic                        lx_in_word;
	logic [1:0]                  lx_quote;
	logic [1:0]                  lx_held;
	logic [scl_pkg::TOKEN_W-1:0] lx_tokens;

	int unsigned cmd_total;
	int unsigned cmd_count;
	int unsigned fail_count;
	int unsigned send_idle;
	int unsigned recv_idle;
	int unsigned hold_req;
	int unsigned hold_seen;
	int unsigned hold_left;
	int unsigned line_no;
	logic        fire_cmd;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 200000);
		$display("FAIL");
		$finish;
	end

	// ---------------------------------------------------------------- lexer model

	function automatic bit is_blank(input logic [7:0] b);
		return b == scl_pkg::CH_SPACE || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic bit has_room();
		return int'(lx_tokens) + 1 < int'(TOKEN_CAPACITY);
	endfunction

	task automatic put_token(input logic [2:0] kind, input logic [7:0] ch,
			input logic [scl_pkg::TOKEN_W-1:0] idx,
			input logic [scl_pkg::TOKEN_W-1:0] total);
		scl_pkg::tok_t t;
		t.kind        = kind;
		t.char_value  = ch;
		t.token_index = idx;
		t.token_total = total;
		t.last        = 1'b0;
		step_toks.push_back(t);
	endtask

	task automatic add_op(input logic [2:0] kind);
		put_token(kind, 8'd0, lx_tokens, '0);
		lx_tokens = lx_tokens + 1'b1;
	endtask

	task automatic close_word();
		put_token(scl_pkg::KIND_END, 8'd0, lx_tokens, '0);
		lx_tokens  = lx_tokens + 1'b1;
		lx_in_word = 1'b0;
		lx_quote   = scl_pkg::QUOTE_NONE;
	endtask

	// byte seen while a word is open and nothing is held
	task automatic word_byte(input logic [7:0] b);
		if (lx_quote != scl_pkg::QUOTE_NONE) begin
			if ((lx_quote == scl_pkg::QUOTE_SINGLE && b == scl_pkg::CH_SQUOT) ||
					(lx_quote == scl_pkg::QUOTE_DOUBLE && b == scl_pkg::CH_DQUOT))
				lx_quote = scl_pkg::QUOTE_NONE;
			else
				put_token(scl_pkg::KIND_CHAR, b, lx_tokens, '0);
		end else if (b == scl_pkg::CH_SQUOT) begin
			lx_quote = scl_pkg::QUOTE_SINGLE;
		end else if (b == scl_pkg::CH_DQUOT) begin
			lx_quote = scl_pkg::QUOTE_DOUBLE;
		end else if (is_blank(b) || b == scl_pkg::CH_PIPE || b == scl_pkg::CH_GT) begin
			close_word();
			gap_byte(b);
		end else if (b == scl_pkg::CH_AMP) begin
			lx_held = scl_pkg::HELD_AMP;
		end else begin
			put_token(scl_pkg::KIND_CHAR, b, lx_tokens, '0);
		end
	endtask

	// byte seen between words with nothing held
	task automatic gap_byte(input logic [7:0] b);
		if (!has_room() || is_blank(b)) begin
		end else if (b == scl_pkg::CH_AMP) begin
			lx_held = scl_pkg::HELD_AMP;
		end else if (b == scl_pkg::CH_GT) begin
			lx_held = scl_pkg::HELD_GT;
		end else if (b == scl_pkg::CH_LT) begin
			add_op(scl_pkg::KIND_IN);
		end else if (b == scl_pkg::CH_PIPE) begin
			add_op(scl_pkg::KIND_PIPE);
		end else begin
			lx_in_word = 1'b1;
			word_byte(b);
		end
	endtask

	task automatic lex_byte(input scl_pkg::cmd_t c);
		logic [7:0] b;
		b = c.byte_value;
		step_toks.delete();
		if (c.line_end) begin
			if (lx_held == scl_pkg::HELD_AMP) begin
				put_token(scl_pkg::KIND_CHAR, scl_pkg::CH_AMP, lx_tokens, '0);
				lx_in_word = 1'b1;
			end else if (lx_held == scl_pkg::HELD_GT) begin
				add_op(scl_pkg::KIND_OUT);
			end
			lx_held = scl_pkg::HELD_NONE;
			if (lx_in_word)
				close_word();
			put_token(scl_pkg::KIND_DONE, 8'd0, '0, lx_tokens);
			lx_in_word = 1'b0;
			lx_quote   = scl_pkg::QUOTE_NONE;
			lx_held    = scl_pkg::HELD_NONE;
			lx_tokens  = '0;
		end else if (lx_held == scl_pkg::HELD_AMP) begin
			lx_held = scl_pkg::HELD_NONE;
			if (b == scl_pkg::CH_AMP) begin
				if (lx_in_word)
					close_word();
				if (has_room())
					add_op(scl_pkg::KIND_AND_IF);
			end else begin
				put_token(scl_pkg::KIND_CHAR, scl_pkg::CH_AMP, lx_tokens, '0);
				lx_in_word = 1'b1;
				word_byte(b);
			end
		end else if (lx_held == scl_pkg::HELD_GT) begin
			lx_held = scl_pkg::HELD_NONE;
			if (b == scl_pkg::CH_GT) begin
				add_op(scl_pkg::KIND_APPEND);
			end else begin
				add_op(scl_pkg::KIND_OUT);
				gap_byte(b);
			end
		end else if (lx_in_word) begin
			word_byte(b);
		end else begin
			gap_byte(b);
		end
		if (step_toks.size() != 0)
			step_toks[step_toks.size() - 1].last = 1'b1;
		foreach (step_toks[i])
			expected_toks.push_back(step_toks[i]);
	endtask

	// ---------------------------------------------------------------- stimulus

	task automatic add_byte(input logic [7:0] b);
		scl_pkg::cmd_t c;
		c.byte_value = b;
		c.line_end   = 1'b0;
		pending_cmds.push_back(c);
	endtask

	task automatic add_end(input logic [7:0] b);
		scl_pkg::cmd_t c;
		c.byte_value = b;
		c.line_end   = 1'b1;
		pending_cmds.push_back(c);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 19))
			9:       return scl_pkg::CH_SPACE;
			10:      return 8'($urandom_range(9, 13));
			11, 12:  return scl_pkg::CH_AMP;
			13, 14:  return scl_pkg::CH_GT;
			15:      return scl_pkg::CH_LT;
			16:      return scl_pkg::CH_PIPE;
			17:      return scl_pkg::CH_SQUOT;
			18:      return scl_pkg::CH_DQUOT;
			8, 19:   return 8'($urandom_range(0, 255));
			default: return 8'h61 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	// operator-heavy byte so that a long line runs past token capacity
	function automatic logic [7:0] pick_dense();
		case ($urandom_range(0, 7))
			0, 1:    return scl_pkg::CH_PIPE;
			2, 3:    return scl_pkg::CH_LT;
			4:       return scl_pkg::CH_GT;
			5:       return scl_pkg::CH_AMP;
			6:       return scl_pkg::CH_SPACE;
			default: return 8'h61 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	task automatic fill_stimulus();
		int unsigned len;
		// empty line whose end word carries a byte that must be ignored
		add_end(8'hFF);
		// zero and all-ones bytes in a word, the &&, >>, > and | operators, '<' inside a word,
		// empty quoted word, held '&' before a quote, unclosed quote at line end
		add_text("x");
		add_byte(8'h00);
		add_byte(8'hFF);
		add_text(" &&>>>y<|'' &\"a");
		add_end(8'h00);
		// lone '<' then a held '&' at line end
		add_text("<&");
		add_end(8'h5A);
		// held '>' at line end
		add_text(">");
		add_end(8'hA5);

		line_no = 0;
		while (pending_cmds.size() < DIRECTED_PLUS_RANDOM) begin
			if (line_no == 2 || line_no % 25 == 12) begin
				for (int i = 0; i < 90; i++)
					add_byte(pick_dense());
			end else begin
				len = $urandom_range(0, 16);
				for (int i = 0; i < int'(len); i++)
					add_byte(pick_byte());
			end
			add_end(8'($urandom_range(0, 255)));
			line_no++;
		end
	endtask

	// ---------------------------------------------------------------- driver

	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.data  <= '0;
		end else if (!cmd_ch.valid || fire_cmd) begin
			if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
				cmd_ch.valid <= 1'b1;
				cmd_ch.data  <= pending_cmds.pop_front();
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// receiver with one long hold-off to back the block up
	always @(negedge clk) begin
		if (!arst_n) begin
			tok_ch.ready <= 1'b0;
			hold_seen    <= 0;
			hold_left    <= 0;
		end else if (hold_req != hold_seen) begin
			hold_seen    <= hold_req;
			hold_left    <= HOLD_CYCLES;
			tok_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			tok_ch.ready <= 1'b0;
		end else begin
			tok_ch.ready <= $urandom_range(0, 99) >= recv_idle;
		end
	end

	// ---------------------------------------------------------------- monitor

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		scl_pkg::tok_t want;
		scl_pkg::tok_t got;
		fire_cmd <= arst_n && cmd_ch.valid && cmd_ch.ready;
		if (!arst_n) begin
			lx_in_word = 1'b0;
			lx_quote   = scl_pkg::QUOTE_NONE;
			lx_held    = scl_pkg::HELD_NONE;
			lx_tokens  = '0;
			cmd_count  = 0;
			fail_count = 0;
		end
		if (arst_n && tok_ch.valid && tok_ch.ready) begin
			got = tok_ch.data;
			if (expected_toks.size() == 0) begin
				$error("token word with nothing expected: kind %0d", got.kind);
				fail_count++;
			end else begin
				want = expected_toks.pop_front();
				check_field("kind", want.kind, got.kind);
				check_field("char_value", want.char_value, got.char_value);
				check_field("token_index", want.token_index, got.token_index);
				check_field("token_total", want.token_total, got.token_total);
				check_field("last", want.last, got.last);
			end
		end
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			lex_byte(cmd_ch.data);
			cmd_count++;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n     = 1'b0;
		hold_req   = 0;
		send_idle  = 35;
		recv_idle  = 56;
		fill_stimulus();
		cmd_total = pending_cmds.size();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_count < cmd_total / 3)
			@(posedge clk);
		send_idle = 56;
		recv_idle = 35;
		while (cmd_count < 2 * cmd_total / 3)
			@(posedge clk);
		send_idle = 0;
		recv_idle = 0;
		hold_req++;
		while (cmd_count < cmd_total)
			@(posedge clk);
		while (expected_toks.size() != 0)
			@(posedge clk);
		// catch any stray words after the last expected one
		repeat (20) @(posedge clk);

		if (fail_count == 0 && expected_toks.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
